FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the descending argsort unit.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/core/dasort_pkg.sv
// Shared constants and types for the descending argsort unit.
// No dependencies; used by dasort_cell and descending_argsort_unit.
package dasort_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int KEY_WIDTH_DEF = 32;

	// Field widths of the stream payloads
	localparam int KEY_FIELD_W = 32;
	localparam int INDEX_W     = 6;
	localparam int OUT_TDATA_W = 40;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

FILE: rtl/core/dasort_cell.sv
// One cell of the sorted insertion chain: holds a key, its arrival index and a valid bit.
// Depends on dasort_pkg for the control struct.
module dasort_cell #(
	parameter int KW = 32,
	parameter int IW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dasort_pkg::cell_ctl_t ctl,
	input  logic [KW-1:0]         new_key,
	input  logic [IW-1:0]         new_idx,
	input  logic                  prev_keep,
	input  logic                  prev_valid,
	input  logic [KW-1:0]         prev_key,
	input  logic [IW-1:0]         prev_idx,
	input  logic                  next_valid,
	input  logic [KW-1:0]         next_key,
	input  logic [IW-1:0]         next_idx,
	output logic                  keep,
	output logic                  valid,
	output logic [KW-1:0]         key,
	output logic [IW-1:0]         idx
);

	logic          valid_q;
	logic [KW-1:0] key_q;
	logic [IW-1:0] idx_q;

	// Equal keys stay ahead of a newcomer, which keeps the order stable
	assign keep  = valid_q && (key_q >= new_key);
	assign valid = valid_q;
	assign key   = key_q;
	assign idx   = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.ins && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= next_key;
			idx_q <= next_idx;
		end else if (ctl.ins && !keep) begin
			if (prev_keep) begin
				key_q <= new_key;
				idx_q <= new_idx;
			end else begin
				key_q <= prev_key;
				idx_q <= prev_idx;
			end
		end
	end

endmodule

FILE: rtl/core/descending_argsort_unit.sv
// Top level of the descending argsort unit: a chain of dasort_cell plus load/emit control.
// Depends on dasort_pkg, dasort_cell and assert_macros.svh.
//
// Usage: keys arrive on the slave stream, one per transfer, s_tdata holding the key and
// s_tlast marking the final key of a set. Each key is placed in the sorted cell chain in
// the cycle of its transfer, so keys stream in at one per cycle while s_tready is high.
// Each key's index is its arrival position in the set, from 0. Keys beyond MAX_ITEMS are
// dropped; their tlast still closes the set.
// After the tlast transfer, s_tready drops and the chain shifts toward cell 0, one entry
// per cycle while m_tready allows, into the output register: the first result is valid
// once the emit state has taken cell 0 into the output register. Each result carries
// the index and key in descending key order; equal keys keep arrival order; m_tlast
// marks the final result. A stall on m_tready holds the output register and freezes
// the chain. s_tready returns once the last result is loaded into the output register,
// so the next set can load while that result waits.
// Reset clears all valid bits, the fill count and the output valid; nothing needs to be
// swept, and s_tready is high out of reset.
`include "assert_macros.svh"

module descending_argsort_unit #(
	parameter int MAX_ITEMS = dasort_pkg::MAX_ITEMS_DEF,
	parameter int KEY_WIDTH = dasort_pkg::KEY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] key
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [5:0] index, [37:6] key_out, [39:38] zero
	output logic        m_tlast
);

	localparam int KFW   = dasort_pkg::KEY_FIELD_W;
	localparam int IDXO  = dasort_pkg::INDEX_W;
	localparam int PAD_W = dasort_pkg::OUT_TDATA_W - IDXO - KFW;
	localparam int KW    = (KEY_WIDTH < KFW) ? KEY_WIDTH : KFW;
	localparam int IW    = $clog2(MAX_ITEMS);
	localparam int CW    = $clog2(MAX_ITEMS + 1);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic          state_q;
	logic [CW-1:0] count_q;
	logic          m_valid_q;
	logic [IDXO-1:0] out_idx_q;
	logic [KFW-1:0]  out_key_q;
	logic          out_last_q;

	logic          in_xfer;
	logic          full;
	logic          load_out;
	logic          final_loaded;
	logic [KW-1:0] new_key;
	dasort_pkg::cell_ctl_t ctl;

	logic [MAX_ITEMS-1:0] cell_valid;
	logic [MAX_ITEMS-1:0] cell_keep;
	logic [KW-1:0]        cell_key [MAX_ITEMS];
	logic [IW-1:0]        cell_idx [MAX_ITEMS];

	assign s_tready  = (state_q == ST_LOAD);
	assign in_xfer   = s_tvalid && s_tready;
	assign full      = (count_q == CW'(MAX_ITEMS));
	assign new_key   = s_tdata[KW-1:0];
	assign load_out  = (state_q == ST_EMIT) && (!m_valid_q || m_tready);
	assign ctl.ins   = in_xfer && !full;
	assign ctl.shift = load_out;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic          prev_keep;
		logic          prev_valid;
		logic [KW-1:0] prev_key;
		logic [IW-1:0] prev_idx;
		logic          next_valid;
		logic [KW-1:0] next_key;
		logic [IW-1:0] next_idx;

		if (i == 0) begin : g_head
			assign prev_keep  = 1'b1;
			assign prev_valid = 1'b0;
			assign prev_key   = '0;
			assign prev_idx   = '0;
		end else begin : g_body
			assign prev_keep  = cell_keep[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_key   = cell_key[i-1];
			assign prev_idx   = cell_idx[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_key   = '0;
			assign next_idx   = '0;
		end else begin : g_link
			assign next_valid = cell_valid[i+1];
			assign next_key   = cell_key[i+1];
			assign next_idx   = cell_idx[i+1];
		end

		dasort_cell #(
			.KW(KW),
			.IW(IW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_key   (new_key),
			.new_idx   (count_q[IW-1:0]),
			.prev_keep (prev_keep),
			.prev_valid(prev_valid),
			.prev_key  (prev_key),
			.prev_idx  (prev_idx),
			.next_valid(next_valid),
			.next_key  (next_key),
			.next_idx  (next_idx),
			.keep      (cell_keep[i]),
			.valid     (cell_valid[i]),
			.key       (cell_key[i]),
			.idx       (cell_idx[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
					end
					if (ctl.ins) begin
						count_q <= count_q + CW'(1);
					end
					if (in_xfer && s_tlast) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						m_valid_q <= 1'b1;
						count_q   <= count_q - CW'(1);
						if (count_q == CW'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Take cell 0 into the output register while the chain advances
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= IDXO'(cell_idx[0]);
			out_key_q  <= KFW'(cell_key[0]);
			out_last_q <= (count_q == CW'(1));
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_key_q, out_idx_q};
	assign m_tlast  = out_last_q;

	assign final_loaded = m_valid_q && out_last_q;

	`ASSERT_CLK(a_count_range, count_q <= CW'(MAX_ITEMS), "fill count beyond chain length")
	`ASSERT_CLK(a_count_cells, $countones(cell_valid) == int'(count_q), "valid cells miscounted")
	`ASSERT_CLK(a_sorted_head, cell_valid[1] |-> (cell_key[0] >= cell_key[1]), "head unsorted")
	`ASSERT_CLK(a_final_frees, $rose(final_loaded) |-> s_tready, "input held after final")
	`ASSERT_NEVER(a_emit_empty, (state_q == ST_EMIT) && (count_q == '0), "empty emit")

endmodule
